### sv/rational_arith_reduce_assert.svh
// Assertion macros for the rational fraction reduce block.
// Included by modules that carry concurrent checks.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RAR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define RAR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### sv/rar_pkg.sv
// Shared types and constants for the rational fraction reduce block.
// No dependencies.
`timescale 1ns / 1ps
package rar_pkg;
   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int NUM_W = 33;
   localparam int DEN_W = 32;
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture operands, form magnitudes and signs
      logic mul;      // cross products
      logic comb;     // raw numerator and denominator
      logic gstart;   // start a remainder division
      logic gswap;    // euclid step: x <= y, y <= rem
      logic qsel;     // divide target: 0 numerator, 1 denominator
      logic qstore;   // store quotient
      logic dstep;    // one bit of the shared divider
      logic finish;   // build result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic err;
      logic y_zero;
      logic div_done;
   } sts_type;
endpackage

### sv/rar_datapath.sv
// Datapath: operand capture, cross multiply, shared restoring divider.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_datapath #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 command,
   input  logic [OPERAND_WIDTH-1:0]   num_a,
   input  logic [OPERAND_WIDTH-1:0]   den_a,
   input  logic [OPERAND_WIDTH-1:0]   num_b,
   input  logic [OPERAND_WIDTH-1:0]   den_b,
   input  rar_pkg::ctl_type           ctl,
   output rar_pkg::sts_type           sts,
   output logic [rar_pkg::NUM_W-1:0]  res_num,
   output logic [rar_pkg::DEN_W-1:0]  res_den,
   output logic                       err_flag
);
   import rar_pkg::*;
   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int MW = PW + 1;
   localparam int CW = $clog2(MW + 1);

   logic [W-1:0]  ma_ff, mb_ff, mc_ff, md_ff;
   logic          sa_ff, sb_ff, sc_ff, sd_ff;
   logic [1:0]    cmd_ff;
   logic          err_ff;
   logic [PW-1:0] p1_ff, p2_ff, p3_ff;
   logic          s1_ff, s2_ff, s3_ff;
   logic [MW-1:0] nmag_ff, dmag_ff;
   logic          nneg_ff;
   logic [MW-1:0] x_ff, y_ff;
   logic [MW-1:0] dq_ff, dr_ff, dv_ff;
   logic [CW-1:0] dcnt_ff;
   logic [MW-1:0] qn_ff, qd_ff;
   logic [NUM_W-1:0] rnum_ff;
   logic [DEN_W-1:0] rden_ff;
   logic          rerr_ff;

   logic [W-1:0]  ma_in, mb_in, mc_in, md_in;
   logic          sc_in;
   logic [MW:0]   rtry;
   logic [MW-1:0] radd;
   logic          nneg_in;
   logic [MW-1:0] nmag_in;
   logic [MW-1:0] gval;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // operand magnitudes; negating subtract flips sign of c
   always_comb begin
      ma_in = mag_of(num_a);
      mb_in = mag_of(den_a);
      mc_in = mag_of(num_b);
      md_in = mag_of(den_b);
      sc_in = (command == CMD_SUB) ? (~num_b[W-1] & (|num_b)) : num_b[W-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ma_ff <= ma_in; mb_ff <= mb_in; mc_ff <= mc_in; md_ff <= md_in;
         sa_ff <= num_a[W-1]; sb_ff <= den_a[W-1];
         sc_ff <= sc_in; sd_ff <= den_b[W-1];
         cmd_ff <= command;
         err_ff <= ~(|den_a) | ~(|den_b) | ((command == CMD_DIV) & ~(|num_b));
      end
   end

   // cross products, one multiplier per product
   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         if (cmd_ff == CMD_MUL) begin
            p1_ff <= PW'(ma_ff) * PW'(mc_ff); s1_ff <= sa_ff ^ sc_ff;
         end else begin
            p1_ff <= PW'(ma_ff) * PW'(md_ff); s1_ff <= sa_ff ^ sd_ff;
         end
         p2_ff <= PW'(mc_ff) * PW'(mb_ff); s2_ff <= sc_ff ^ sb_ff;
         if (cmd_ff == CMD_DIV) begin
            p3_ff <= PW'(mb_ff) * PW'(mc_ff); s3_ff <= sb_ff ^ sc_ff;
         end else begin
            p3_ff <= PW'(mb_ff) * PW'(md_ff); s3_ff <= sb_ff ^ sd_ff;
         end
      end
   end

   // signed-magnitude sum for add and subtract; multiply and divide pass p1 through
   always_comb begin
      radd = '0;
      nneg_in = 1'b0;
      if (s1_ff == s2_ff) begin
         radd = MW'(p1_ff) + MW'(p2_ff);
         nneg_in = s1_ff;
      end else if (p1_ff >= p2_ff) begin
         radd = MW'(p1_ff - p2_ff);
         nneg_in = s1_ff;
      end else begin
         radd = MW'(p2_ff - p1_ff);
         nneg_in = s2_ff;
      end
      if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) begin
         radd = MW'(p1_ff);
         nneg_in = s1_ff;
      end
      nmag_in = radd;
   end

   // raw fraction and euclid operands; result sign combines numerator and denominator signs; euclid swap step
   always_ff @(posedge clock) begin
      if (ctl.comb) begin
         nmag_ff <= nmag_in;
         nneg_ff <= nneg_in ^ s3_ff;
         dmag_ff <= MW'(p3_ff);
         x_ff    <= nmag_in;
         y_ff    <= MW'(p3_ff);
      end else if (ctl.gswap && !ctl.gstart) begin
         x_ff <= y_ff;
         y_ff <= dr_ff;
      end
   end

   assign gval = (x_ff == '0) ? MW'(1) : x_ff;

   // restoring divider, one quotient bit per cycle while dstep is high
   assign rtry = {dr_ff, dq_ff[MW-1]} - {1'b0, dv_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (ctl.gstart) begin
         dcnt_ff <= CW'(MW);
      end else if (ctl.dstep && dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (ctl.gstart) begin
         dr_ff <= '0;
         if (ctl.qsel == 1'b0 && !ctl.gswap) begin
            dq_ff <= nmag_ff; dv_ff <= gval;
         end else if (ctl.gswap) begin
            dq_ff <= x_ff; dv_ff <= y_ff;
         end else begin
            dq_ff <= dmag_ff; dv_ff <= gval;
         end
      end else if (ctl.dstep && dcnt_ff != '0) begin
         if (!rtry[MW]) begin
            dr_ff <= rtry[MW-1:0];
            dq_ff <= {dq_ff[MW-2:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[MW-2:0], dq_ff[MW-1]};
            dq_ff <= {dq_ff[MW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.qstore) begin
         if (ctl.qsel) qd_ff <= dq_ff;
         else          qn_ff <= dq_ff;
      end
   end

   // result: sign on numerator, wrap to field widths; 0/0 on error
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rerr_ff <= err_ff;
         if (err_ff) begin
            rnum_ff <= '0; rden_ff <= '0;
         end else begin
            rnum_ff <= (nneg_ff && qn_ff != '0) ? NUM_W'(~qn_ff + 1'b1) : NUM_W'(qn_ff);
            rden_ff <= DEN_W'(qd_ff);
         end
      end
   end

   assign sts.err      = err_ff;
   assign sts.y_zero   = (y_ff == '0);
   assign sts.div_done = (dcnt_ff == '0);
   assign res_num  = rnum_ff;
   assign res_den  = rden_ff;
   assign err_flag = rerr_ff;
endmodule

### sv/rar_ctrl.sv
// Controller: sequences load, multiply, euclid loop and final divides.
// Depends on rar_pkg and the assertion macro header.
`timescale 1ns / 1ps
module rar_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rar_pkg::sts_type sts,
   output rar_pkg::ctl_type ctl,
   output logic             busy,
   output logic             rsp_valid
);
   import rar_pkg::*;
   `include "rational_arith_reduce_assert.svh"

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL  = 4'd1;
   localparam logic [3:0] ST_COMB = 4'd2;
   localparam logic [3:0] ST_GTST = 4'd3;
   localparam logic [3:0] ST_GDIV = 4'd4;
   localparam logic [3:0] ST_NST  = 4'd5;
   localparam logic [3:0] ST_NDIV = 4'd6;
   localparam logic [3:0] ST_DST  = 4'd7;
   localparam logic [3:0] ST_DDIV = 4'd8;
   localparam logic [3:0] ST_FIN  = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       gdiv_ff, gdiv_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      gdiv_in  = gdiv_ff;
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.load = start;
            if (start) state_in = ST_MUL;
         end
         ST_MUL: begin
            ctl.mul = 1'b1;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            ctl.comb = 1'b1;
            state_in = sts.err ? ST_FIN : ST_GTST;
         end
         ST_GTST: begin
            if (sts.y_zero) begin
               state_in = ST_NST;
            end else begin
               ctl.gstart = 1'b1; ctl.gswap = 1'b1;
               state_in = ST_GDIV;
            end
         end
         ST_GDIV: begin
            ctl.dstep = 1'b1;
            if (sts.div_done) begin
               ctl.dstep = 1'b0; ctl.gswap = 1'b1;
               state_in = ST_GTST;
            end
         end
         ST_NST: begin
            ctl.gstart = 1'b1;
            state_in = ST_NDIV;
         end
         ST_NDIV: begin
            ctl.dstep = 1'b1;
            if (sts.div_done) begin
               ctl.dstep = 1'b0; ctl.qstore = 1'b1;
               state_in = ST_DST;
            end
         end
         ST_DST: begin
            ctl.gstart = 1'b1; ctl.qsel = 1'b1;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            ctl.qsel = 1'b1; ctl.dstep = 1'b1;
            if (sts.div_done) begin
               ctl.dstep = 1'b0; ctl.qstore = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ctl.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gdiv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gdiv_ff  <= gdiv_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE) || gdiv_ff;
   assign rsp_valid = (state_ff == ST_OUT);

   `RAR_ASSERT_NXT(a_start_mul, clock, reset, (state_ff == ST_IDLE) && start,
                   state_ff == ST_MUL)
   `RAR_ASSERT_NXT(a_out_one, clock, reset, rsp_valid, !rsp_valid)
   `RAR_ASSERT_IMP(a_swap_nostep, clock, reset, ctl.gswap, !ctl.dstep)
endmodule

### sv/rational_arith_reduce.sv
// Top level of the rational fraction reduce block.
// Depends on rar_pkg, rar_ctrl and rar_datapath.
// Usage:
//  Drive req_* and raise start while busy is low; the item is taken at
//  that edge. The block forms the raw numerator and denominator by cross
//  multiplication, runs Euclid's remainder loop on their magnitudes with
//  a shared bit-serial divider, then divides both by the GCD with the same
//  divider. Error items skip the Euclid loop and the divides.
//  One item at a time; busy stays high through the cycle that shows the
//  result and drops in the cycle after it, so a new item is taken only
//  once the last result has been shown.
//  The result shows on rsp_* for one cycle with rsp_valid high; the
//  receiver cannot stall, so it must take it then.
//  Zero denominators or division by a zero fraction give 0/0, err_flag 1.
//  Reset returns the controller to idle; no result is pending after it.
`timescale 1ns / 1ps
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_command,
   input  logic [OPERAND_WIDTH-1:0]  req_num_a,
   input  logic [OPERAND_WIDTH-1:0]  req_den_a,
   input  logic [OPERAND_WIDTH-1:0]  req_num_b,
   input  logic [OPERAND_WIDTH-1:0]  req_den_b,
   output logic                      rsp_valid,
   output logic [rar_pkg::NUM_W-1:0] rsp_res_num,
   output logic [rar_pkg::DEN_W-1:0] rsp_res_den,
   output logic                      rsp_err_flag
);
   import rar_pkg::*;
   ctl_type ctl;
   sts_type sts;

   rar_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .ctl(ctl),
      .busy(busy), .rsp_valid(rsp_valid)
   );

   rar_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .command(req_command),
      .num_a(req_num_a), .den_a(req_den_a), .num_b(req_num_b), .den_b(req_den_b),
      .ctl(ctl), .sts(sts), .res_num(rsp_res_num), .res_den(rsp_res_den),
      .err_flag(rsp_err_flag)
   );
endmodule

### tb/tb_top.sv
// Self-checking bench for rational_arith_reduce: fraction add, subtract,
// multiply and divide with GCD reduction, checked against a local predictor.
// Depends on rar_pkg and the rational_arith_reduce RTL.
`timescale 1ns / 1ps
module tb_top;
   import rar_pkg::*;

   localparam int OW = OPERAND_WIDTH_DEF;

   typedef struct {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             err;
   } frac_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_command = CMD_ADD;
   logic [OW-1:0]     req_num_a = '0;
   logic [OW-1:0]     req_den_a = '0;
   logic [OW-1:0]     req_num_b = '0;
   logic [OW-1:0]     req_den_b = '0;
   logic              rsp_valid;
   logic [NUM_W-1:0]  rsp_res_num;
   logic [DEN_W-1:0]  rsp_res_den;
   logic              rsp_err_flag;

   frac_result_type pending_fracs[$];
   int           fail_count = 0;
   bit           idle_on = 1'b1;

   rational_arith_reduce dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_num_a(req_num_a), .req_den_a(req_den_a),
      .req_num_b(req_num_b), .req_den_b(req_den_b),
      .rsp_valid(rsp_valid), .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den), .rsp_err_flag(rsp_err_flag)
   );

   always #1 clock = ~clock;

   // Euclid on magnitudes
   function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // reduced fraction for one command
   function automatic frac_result_type reduce_frac(logic [1:0] cmd, logic [OW-1:0] a,
                                                   logic [OW-1:0] b, logic [OW-1:0] c,
                                                   logic [OW-1:0] d);
      frac_result_type res;
      longint          sa, sb, sc, sd, n, m;
      longint unsigned nm, dm, g;
      bit              neg;
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      sc = longint'($signed(c));
      sd = longint'($signed(d));
      if (sb == 0 || sd == 0 || (cmd == CMD_DIV && sc == 0)) begin
         res.num = '0;
         res.den = '0;
         res.err = 1'b1;
         return res;
      end
      case (cmd)
         CMD_ADD: begin n = sa * sd + sc * sb; m = sb * sd; end
         CMD_SUB: begin n = sa * sd - sc * sb; m = sb * sd; end
         CMD_MUL: begin n = sa * sc; m = sb * sd; end
         default: begin n = sa * sd; m = sb * sc; end
      endcase
      nm = (n < 0) ? -n : n;
      dm = (m < 0) ? -m : m;
      g = gcd_mag(nm, dm);
      if (g == 0) g = 1;
      nm = nm / g;
      dm = dm / g;
      neg = ((n < 0) != (m < 0)) && nm != 0;
      res.num = neg ? NUM_W'(-nm) : NUM_W'(nm);
      res.den = DEN_W'(dm);
      res.err = 1'b0;
      return res;
   endfunction

   // hand one item to the block, hold start until taken
   task automatic send_frac(logic [1:0] cmd, logic [OW-1:0] a, logic [OW-1:0] b,
                            logic [OW-1:0] c, logic [OW-1:0] d);
      int gap;
      req_command <= cmd;
      req_num_a   <= a;
      req_den_a   <= b;
      req_num_b   <= c;
      req_den_b   <= d;
      start       <= 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_fracs.push_back(reduce_frac(cmd, a, b, c, d));
      // random idle burst
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [OW-1:0] rand_operand();
      case ($urandom_range(0, 9))
         0, 1, 2: return OW'($signed($urandom_range(0, 40)) - 20);
         3:       return $urandom_range(0, 1) ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
         default: return OW'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [OW-1:0] mx, mn;
      mx = {1'b0, {(OW-1){1'b1}}};
      mn = {1'b1, {(OW-1){1'b0}}};
      send_frac(CMD_ADD, 1, 2, 1, 3);
      send_frac(CMD_SUB, 1, 2, 1, 3);
      send_frac(CMD_MUL, 2, 3, 3, 4);
      send_frac(CMD_DIV, 2, 3, 4, 9);
      send_frac(CMD_ADD, -1, 2, 1, -2);     // result -1
      send_frac(CMD_MUL, 0, 5, 7, 9);       // zero numerator
      send_frac(CMD_ADD, 1, 0, 1, 3);       // zero first denominator
      send_frac(CMD_SUB, 1, 3, 1, 0);       // zero second denominator
      send_frac(CMD_DIV, 1, 3, 0, 5);       // divide by zero fraction
      send_frac(CMD_MUL, 0, 0, 0, 0);
      send_frac(CMD_ADD, mx, 1, mx, 1);
      send_frac(CMD_SUB, mn, 1, mx, 1);
      send_frac(CMD_MUL, mn, 1, mn, 1);
      send_frac(CMD_DIV, mn, mx, mn, mx);
      send_frac(CMD_ADD, mn, mn, mn, mn);
      send_frac(CMD_DIV, 1, mn, mx, 1);
      send_frac(CMD_SUB, -1, -1, -1, -1);
      send_frac(CMD_ADD, '1, '1, '1, '1);
      send_frac(CMD_MUL, mx, mn, mn, mx);
      send_frac(CMD_DIV, -7, 3, -14, 6);
   endtask

   task automatic test_random(int count);
      repeat (count)
         send_frac(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                   rand_operand(), rand_operand());
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      frac_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_fracs.size() == 0) begin
            $error("unexpected result num=%h den=%h err=%b",
                   rsp_res_num, rsp_res_den, rsp_err_flag);
            fail_count++;
         end else begin
            exp_r = pending_fracs.pop_front();
            if (rsp_res_num !== exp_r.num) begin
               $error("res_num expected %h actual %h", exp_r.num, rsp_res_num);
               fail_count++;
            end
            if (rsp_res_den !== exp_r.den) begin
               $error("res_den expected %h actual %h", exp_r.den, rsp_res_den);
               fail_count++;
            end
            if (rsp_err_flag !== exp_r.err) begin
               $error("err_flag expected %b actual %b", exp_r.err, rsp_err_flag);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1500);
      idle_on = 1'b0;
      test_random(230);
      start <= 1'b0;
      while (pending_fracs.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_fracs.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      #50000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

### filelist.f
+incdir+sv
sv/rar_pkg.sv
sv/rar_datapath.sv
sv/rar_ctrl.sv
sv/rational_arith_reduce.sv
tb/tb_top.sv
